// ----- hdl/mag_moment_accumulator_core_macros.svh -----
// ----------------------------------------------------------------------------
// mag moment accumulator assertion macros
// shared property forms for the accumulator core
// ----------------------------------------------------------------------------
`ifndef MAG_MOMENT_ACCUMULATOR_CORE_MACROS_SVH
`define MAG_MOMENT_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define MMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg
// types, codes and constants of the magnetometer moment accumulator
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int MOMENTS     = 23;
	localparam int SUM_W       = 64;
	localparam int COUNT_W     = 13;
	localparam int PROG_W      = 7;
	localparam int FIELD_W     = 16;
	localparam int PROD_W      = 31;
	localparam int DIGIT_W     = 8;
	localparam int DIGITS      = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 13'd8191;
	localparam logic [COUNT_W-1:0] MIN_RESET   = 13'd2000;
	localparam logic [COUNT_W-1:0] MAX_RESET   = 13'd5000;
	localparam logic [11:0]        RECIP_20    = 12'd3277;
	localparam logic [PROG_W-1:0]  PROG_FULL   = 7'd100;
	localparam logic [4:0]         MOMENT_CNT  = 5'd23;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_SPAN_THR = 2'd0,
		REG_MIN_SMP  = 2'd1,
		REG_MAX_SMP  = 2'd2,
		REG_REF_SNS  = 2'd3
	} reg_idx_t;

	// count/20 by reciprocal, exact for 13-bit counts, capped at PROG_FULL and full once the count passes min_smp
	function automatic logic [PROG_W-1:0] progress_of(input logic [COUNT_W-1:0] n,
			input logic [COUNT_W-1:0] min_smp);
		logic [24:0] prod;
		logic [8:0]  q;
		prod = 25'(n) * 25'(RECIP_20);
		q    = prod[24:16];
		if (n > min_smp)
			return PROG_FULL;
		else if (q > 9'(PROG_FULL))
			return PROG_FULL;
		else
			return q[PROG_W-1:0];
	endfunction

endpackage

// ----- hdl/mag_moment_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// mag_moment_accumulator_core
// least-squares ellipsoid fit moment accumulation for raw magnetometer data
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A sample of a present sensor runs
// each of the 23 moments through one shared 31x8 digit multiplier, four digits
// per moment in ST_MUL, then one read-modify-write of the sum memory in ST_ADD;
// then ST_TICK checks the tick and ST_FIN loads the output, after which the
// next transaction can be taken. A read passes ST_RD, ST_RDW and ST_FIN, a
// sample of an absent sensor ST_TICK and ST_FIN, other items go straight to
// ST_FIN; a result held by out_stall delays the next load by the stall length.
// Sums sit in a memory of NUM_SENSORS*23 words of 64 bits with one valid bit
// per word, so a clear or restart takes effect at once with no sweep. The next
// item is accepted while a finished result still waits at the output.
module mag_moment_accumulator_core import mma_pkg::*; #(
	parameter int NUM_SENSORS = 2,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic                      qualified,
	input  logic                      sensor,
	input  logic                      present,
	input  logic signed [15:0]        sample_x,
	input  logic signed [15:0]        sample_y,
	input  logic signed [15:0]        sample_z,
	input  logic                      tick_end,
	input  logic [4:0]                moment,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [63:0]        read_value,
	output logic [12:0]               count,
	output logic [6:0]                progress,
	output logic                      complete,
	output logic                      restarted,
	output logic                      saturated
);

`include "mag_moment_accumulator_core_macros.svh"

	localparam int DEPTH  = NUM_SENSORS * MOMENTS;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_RDW, ST_MUL, ST_ADD, ST_TICK, ST_FIN
	} state_t;

	state_t state_q;

	logic [15:0]        span_thr_q;
	logic [COUNT_W-1:0] min_smp_q, max_smp_q, count_q;
	logic               ref_sns_q;
	logic               done_q, sat_q;
	logic [DEPTH-1:0]   valid_q;
	logic signed [15:0] max_q [3];
	logic signed [15:0] min_q [3];

	logic               sensor_q, tick_q;
	logic [4:0]         moment_q, k_q;
	logic [1:0]         dig_q;
	logic [15:0]        ax_q, ay_q, az_q;
	logic               sx_q, sy_q, sz_q;
	logic [PROD_W-1:0]  x2_q, y2_q, z2_q, xy_q, xz_q, yz_q;
	logic [63:0]        acc_q;
	logic [63:0]        rv_q;
	logic [PROG_W-1:0]  prog_q;
	logic               rst_flag_q;

	logic               out_valid_q, complete_q, restarted_q, saturated_q;
	logic [63:0]        read_value_q;
	logic [COUNT_W-1:0] count_o_q;
	logic [PROG_W-1:0]  progress_q;

	logic signed [15:0] vx, vy, vz;
	logic               in_acc;
	logic [ADDR_W-1:0]  base_addr, ram_addr;
	logic               ram_re, ram_we;
	logic [63:0]        ram_rdata, old_sum, prod_s, sum_new;
	logic [64:0]        sum_w;
	logic [PROD_W-1:0]  op_a, op_b;
	logic               neg;
	logic [31:0]        op_b32;
	logic [DIGIT_W-1:0] digit;
	logic [38:0]        part;
	logic [COUNT_W-1:0] cnt_inc;
	logic [16:0]        span [3];
	logic               spans;

	assign vx = 16'($signed(sample_x[SAMPLE_BITS-1:0]));
	assign vy = 16'($signed(sample_y[SAMPLE_BITS-1:0]));
	assign vz = 16'($signed(sample_z[SAMPLE_BITS-1:0]));

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign base_addr = sensor_q ? ADDR_W'(MOMENTS) : '0;
	assign ram_addr  = base_addr +
		ADDR_W'((state_q == ST_RD || state_q == ST_RDW) ? moment_q : k_q);
	assign ram_re    = (state_q == ST_RD) || (state_q == ST_MUL && dig_q == 2'd0);
	assign ram_we    = (state_q == ST_ADD);

	// operand selection per moment
	always_comb begin
		op_a = '0;
		op_b = '0;
		neg  = 1'b0;
		case (k_q)
			5'd0:  begin op_a = PROD_W'(ax_q); op_b = PROD_W'(1); neg = sx_q; end
			5'd1:  begin op_a = PROD_W'(ax_q); op_b = PROD_W'(ax_q); end
			5'd2:  begin op_a = x2_q; op_b = PROD_W'(ax_q); neg = sx_q; end
			5'd3:  begin op_a = x2_q; op_b = x2_q; end
			5'd4:  begin op_a = PROD_W'(ay_q); op_b = PROD_W'(1); neg = sy_q; end
			5'd5:  begin op_a = PROD_W'(ay_q); op_b = PROD_W'(ay_q); end
			5'd6:  begin op_a = y2_q; op_b = PROD_W'(ay_q); neg = sy_q; end
			5'd7:  begin op_a = y2_q; op_b = y2_q; end
			5'd8:  begin op_a = PROD_W'(az_q); op_b = PROD_W'(1); neg = sz_q; end
			5'd9:  begin op_a = PROD_W'(az_q); op_b = PROD_W'(az_q); end
			5'd10: begin op_a = z2_q; op_b = PROD_W'(az_q); neg = sz_q; end
			5'd11: begin op_a = PROD_W'(ax_q); op_b = PROD_W'(ay_q); neg = sx_q ^ sy_q; end
			5'd12: begin op_a = xy_q; op_b = PROD_W'(ax_q); neg = sy_q; end
			5'd13: begin op_a = xy_q; op_b = PROD_W'(ay_q); neg = sx_q; end
			5'd14: begin op_a = xy_q; op_b = xy_q; end
			5'd15: begin op_a = PROD_W'(ax_q); op_b = PROD_W'(az_q); neg = sx_q ^ sz_q; end
			5'd16: begin op_a = xz_q; op_b = PROD_W'(ax_q); neg = sz_q; end
			5'd17: begin op_a = xz_q; op_b = PROD_W'(az_q); neg = sx_q; end
			5'd18: begin op_a = xz_q; op_b = xz_q; end
			5'd19: begin op_a = PROD_W'(ay_q); op_b = PROD_W'(az_q); neg = sy_q ^ sz_q; end
			5'd20: begin op_a = yz_q; op_b = PROD_W'(ay_q); neg = sz_q; end
			5'd21: begin op_a = yz_q; op_b = PROD_W'(az_q); neg = sy_q; end
			5'd22: begin op_a = yz_q; op_b = yz_q; end
			default: begin op_a = '0; op_b = '0; neg = 1'b0; end
		endcase
	end

	assign op_b32  = 32'(op_b);
	assign digit   = DIGIT_W'(op_b32 >> {~dig_q, 3'b000});
	assign part    = 39'(op_a) * 39'(digit);

	assign old_sum = valid_q[ram_addr] ? ram_rdata : '0;
	assign prod_s  = neg ? (~acc_q + 64'd1) : acc_q;
	assign sum_w   = {old_sum[63], old_sum} + {prod_s[63], prod_s};
	always_comb begin
		if (sum_w[64] != sum_w[63])
			sum_new = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sum_new = sum_w[63:0];
	end

	assign cnt_inc = (count_q == COUNT_MAX) ? count_q : count_q + 13'd1;
	always_comb begin
		spans = 1'b1;
		for (int a = 0; a < 3; a++) begin
			span[a] = 17'(max_q[a]) - 17'(min_q[a]);
			if (!(span[a] > {1'b0, span_thr_q}))
				spans = 1'b0;
		end
	end

	mma_ram #(
		.WIDTH(SUM_W),
		.DEPTH(DEPTH)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(sum_new),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			span_thr_q  <= '0;
			min_smp_q   <= MIN_RESET;
			max_smp_q   <= MAX_RESET;
			ref_sns_q   <= 1'b0;
			count_q     <= '0;
			done_q      <= 1'b0;
			sat_q       <= 1'b0;
			valid_q     <= '0;
			for (int a = 0; a < 3; a++) begin
				max_q[a] <= '0;
				min_q[a] <= '0;
			end
			k_q         <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SPAN_THR: span_thr_q <= cfg_data;
					REG_MIN_SMP:  min_smp_q  <= cfg_data[COUNT_W-1:0];
					REG_MAX_SMP:  max_smp_q  <= cfg_data[COUNT_W-1:0];
					REG_REF_SNS:  ref_sns_q  <= cfg_data[0];
					default:      ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sensor_q   <= sensor;
						tick_q     <= tick_end;
						moment_q   <= moment;
						ax_q       <= vx[15] ? 16'(-vx) : 16'(vx);
						ay_q       <= vy[15] ? 16'(-vy) : 16'(vy);
						az_q       <= vz[15] ? 16'(-vz) : 16'(vz);
						sx_q       <= vx[15];
						sy_q       <= vy[15];
						sz_q       <= vz[15];
						rv_q       <= '0;
						rst_flag_q <= 1'b0;
						k_q        <= '0;
						dig_q      <= '0;
						acc_q      <= '0;
						case (op_t'(op))
							OP_CLEAR: begin
								valid_q <= '0;
								count_q <= '0;
								sat_q   <= 1'b0;
								done_q  <= 1'b0;
								for (int a = 0; a < 3; a++) begin
									max_q[a] <= '0;
									min_q[a] <= '0;
								end
								prog_q  <= '0;
								state_q <= ST_FIN;
							end
							OP_SAMPLE: begin
								if (!qualified) begin
									prog_q  <= '0;
									state_q <= ST_FIN;
								end else if (done_q) begin
									prog_q  <= progress_of(count_q, min_smp_q);
									state_q <= ST_FIN;
								end else begin
									if (sensor == ref_sns_q) begin
										if (vx > max_q[0]) max_q[0] <= vx;
										else if (vx < min_q[0]) min_q[0] <= vx;
										if (vy > max_q[1]) max_q[1] <= vy;
										else if (vy < min_q[1]) min_q[1] <= vy;
										if (vz > max_q[2]) max_q[2] <= vz;
										else if (vz < min_q[2]) min_q[2] <= vz;
									end
									if (present && ((NUM_SENSORS > 1) || !sensor))
										state_q <= ST_MUL;
									else
										state_q <= ST_TICK;
								end
							end
							default: begin
								prog_q <= progress_of(count_q, min_smp_q);
								if (op_t'(op) == OP_READ && moment == MOMENT_CNT)
									rv_q <= 64'(count_q);
								if (op_t'(op) == OP_READ && moment < MOMENT_CNT &&
										((NUM_SENSORS > 1) || !sensor))
									state_q <= ST_RD;
								else
									state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					rv_q    <= old_sum;
					state_q <= ST_FIN;
				end
				ST_MUL: begin
					acc_q <= {acc_q[55:0], 8'd0} + 64'(part);
					dig_q <= dig_q + 2'd1;
					if (dig_q == 2'(DIGITS - 1))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					valid_q[ram_addr] <= 1'b1;
					if (sum_w[64] != sum_w[63])
						sat_q <= 1'b1;
					case (k_q)
						5'd1:    x2_q <= acc_q[PROD_W-1:0];
						5'd5:    y2_q <= acc_q[PROD_W-1:0];
						5'd9:    z2_q <= acc_q[PROD_W-1:0];
						5'd11:   xy_q <= acc_q[PROD_W-1:0];
						5'd15:   xz_q <= acc_q[PROD_W-1:0];
						5'd19:   yz_q <= acc_q[PROD_W-1:0];
						default: ;
					endcase
					acc_q <= '0;
					if (k_q == MOMENT_CNT - 5'd1) begin
						state_q <= ST_TICK;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= ST_MUL;
					end
				end
				ST_TICK: begin
					if (tick_q) begin
						prog_q <= progress_of(cnt_inc, min_smp_q);
						if (spans && cnt_inc > min_smp_q) begin
							count_q <= cnt_inc;
							done_q  <= 1'b1;
						end else if (cnt_inc > max_smp_q) begin
							valid_q    <= '0;
							count_q    <= '0;
							sat_q      <= 1'b0;
							rst_flag_q <= 1'b1;
						end else begin
							count_q <= cnt_inc;
						end
					end else begin
						prog_q <= progress_of(count_q, min_smp_q);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						read_value_q <= rv_q;
						count_o_q    <= count_q;
						progress_q   <= prog_q;
						complete_q   <= done_q;
						restarted_q  <= rst_flag_q;
						saturated_q  <= sat_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign count      = count_o_q;
	assign progress   = progress_q;
	assign complete   = complete_q;
	assign restarted  = restarted_q;
	assign saturated  = saturated_q;

	`MMA_ASSERT_IMP(a_restart_clears, out_valid && restarted, count == '0, "restart left count")
	`MMA_ASSERT_IMP(a_prog_range, out_valid, progress <= PROG_FULL, "progress above full")
	`MMA_ASSERT_NXT(a_last_moment, state_q == ST_ADD && k_q == MOMENT_CNT - 5'd1, state_q == ST_TICK, "sequencer overran moments")
	`MMA_ASSERT_IMP(a_digit_idle, state_q != ST_MUL, dig_q == 2'd0, "digit counter out of step")

endmodule

// ----- hdl/mma_ram.sv -----
// ----------------------------------------------------------------------------
// mma_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 46
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for mag_moment_accumulator_core: a queue-fed driver and
// a clocked monitor compare every result transaction with a cycle-free
// predictor of the moment sums, span tracking, count and flags, across
// several register settings, random pacing and back-pressure on both sides
// ----------------------------------------------------------------------------
module tb_top;
	import mma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t                op;
		bit                 qual;
		bit                 sns;
		bit                 pres;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		bit                 tick;
		logic [4:0]         mom;
	} mag_item_t;

	typedef struct {
		logic signed [63:0] rv;
		logic [12:0]        cnt;
		logic [6:0]         prog;
		bit                 cmp;
		bit                 rst;
		bit                 sat;
	} mag_result_t;

	localparam longint SUM_HI = 64'sh7fff_ffff_ffff_ffff;
	localparam longint SUM_LO = 64'sh8000_0000_0000_0000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	reg_idx_t           cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic               qualified;
	logic               sensor;
	logic               present;
	logic signed [15:0] sample_x;
	logic signed [15:0] sample_y;
	logic signed [15:0] sample_z;
	logic               tick_end;
	logic [4:0]         moment;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] read_value;
	logic [12:0]        count;
	logic [6:0]         progress;
	logic               complete;
	logic               restarted;
	logic               saturated;

	mag_moment_accumulator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .qualified(qualified), .sensor(sensor), .present(present),
		.sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
		.tick_end(tick_end), .moment(moment),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .count(count), .progress(progress),
		.complete(complete), .restarted(restarted), .saturated(saturated)
	);

	// predictor state and register copies
	longint    sum_bank [2][MOMENTS];
	int        n_samples;
	int        ax_max [3];
	int        ax_min [3];
	bit        done_sticky;
	bit        sat_sticky;
	int        span_thr;
	int        min_smp;
	int        max_smp;
	int        ref_sns;

	mag_item_t   items_to_send [$];
	mag_result_t expected_results [$];
	mag_item_t   on_bus;
	bit          in_taken;
	bit          out_taken;
	int          send_gap;
	int          stall_left;
	int          rx_hold_cycles;
	int          quiet_pct;
	int          errors;

	function automatic longint sum_add(longint a, longint b);
		logic signed [64:0] w;
		w = a;
		w = w + b;
		if (w[64] != w[63]) begin
			sat_sticky = 1;
			return w[64] ? SUM_LO : SUM_HI;
		end
		return w[63:0];
	endfunction

	function automatic int pct_of(int n);
		if (n > min_smp)
			return 100;
		return (n / 20 > 100) ? 100 : n / 20;
	endfunction

	function automatic void wipe_sums();
		foreach (sum_bank[s, k])
			sum_bank[s][k] = 0;
		n_samples = 0;
		sat_sticky = 0;
	endfunction

	function automatic mag_result_t predict_accumulator(mag_item_t it);
		mag_result_t r;
		longint x, y, z;
		longint m [MOMENTS];
		int v [3];
		bit spans;
		v[0] = it.x;
		v[1] = it.y;
		v[2] = it.z;
		x = it.x;
		y = it.y;
		z = it.z;
		r.rv = 0;
		r.rst = 0;
		r.prog = 0;
		if (it.op == OP_CLEAR) begin
			wipe_sums();
			for (int a = 0; a < 3; a++) begin
				ax_max[a] = 0;
				ax_min[a] = 0;
			end
			done_sticky = 0;
		end else if (it.op == OP_SAMPLE) begin
			if (!it.qual)
				r.prog = 0;
			else if (done_sticky)
				r.prog = 7'(pct_of(n_samples));
			else begin
				if (it.sns == ref_sns) begin
					for (int a = 0; a < 3; a++) begin
						if (v[a] > ax_max[a])
							ax_max[a] = v[a];
						else if (v[a] < ax_min[a])
							ax_min[a] = v[a];
					end
				end
				if (it.pres) begin
					m[0] = x;           m[1] = x * x;         m[2] = x * x * x;
					m[3] = m[1] * m[1];
					m[4] = y;           m[5] = y * y;         m[6] = y * y * y;
					m[7] = m[5] * m[5];
					m[8] = z;           m[9] = z * z;         m[10] = z * z * z;
					m[11] = x * y;      m[12] = m[11] * x;    m[13] = m[11] * y;
					m[14] = m[11] * m[11];
					m[15] = x * z;      m[16] = m[15] * x;    m[17] = m[15] * z;
					m[18] = m[15] * m[15];
					m[19] = y * z;      m[20] = m[19] * y;    m[21] = m[19] * z;
					m[22] = m[19] * m[19];
					for (int k = 0; k < MOMENTS; k++)
						sum_bank[it.sns][k] = sum_add(sum_bank[it.sns][k], m[k]);
				end
				if (it.tick) begin
					if (n_samples < int'(COUNT_MAX))
						n_samples++;
					spans = 1;
					for (int a = 0; a < 3; a++)
						if (!(ax_max[a] - ax_min[a] > span_thr))
							spans = 0;
					r.prog = 7'(pct_of(n_samples));
					if (spans && n_samples > min_smp)
						done_sticky = 1;
					else if (n_samples > max_smp) begin
						wipe_sums();
						r.rst = 1;
					end
				end else
					r.prog = 7'(pct_of(n_samples));
			end
		end else begin
			if (it.op == OP_READ) begin
				if (it.mom == MOMENT_CNT)
					r.rv = longint'(n_samples);
				else if (it.mom < MOMENT_CNT)
					r.rv = sum_bank[it.sns][it.mom];
			end
			r.prog = 7'(pct_of(n_samples));
		end
		r.cnt = 13'(n_samples);
		r.cmp = done_sticky;
		r.sat = sat_sticky;
		return r;
	endfunction

	task automatic report(string fld, longint exp_v, longint act_v);
		$display("%0t mismatch %s: expected %0d actual %0d", $realtime, fld, exp_v, act_v);
		errors++;
	endtask

	// input transaction capture
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(predict_accumulator(on_bus));
			in_taken = 1;
		end
	end

	// driver
	always @(negedge clk) begin
		logic nv;
		nv = in_valid;
		if (in_taken) begin
			nv = 0;
			in_taken = 0;
		end
		if (arst_n && !nv) begin
			if (send_gap > 0)
				send_gap--;
			else if (items_to_send.size() > 0) begin
				on_bus = items_to_send.pop_front();
				op <= on_bus.op;
				qualified <= on_bus.qual;
				sensor <= on_bus.sns;
				present <= on_bus.pres;
				sample_x <= on_bus.x;
				sample_y <= on_bus.y;
				sample_z <= on_bus.z;
				tick_end <= on_bus.tick;
				moment <= on_bus.mom;
				nv = 1;
				send_gap = ($urandom_range(0, 99) < quiet_pct) ? 0 : $urandom_range(0, 18);
			end
		end
		in_valid <= nv;
	end

	// receiver pacing
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 0;
			stall_left = ($urandom_range(0, 99) < quiet_pct) ? 0 : $urandom_range(0, 18);
		end
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			out_stall <= 1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else
			out_stall <= 0;
	end

	// monitor
	always @(posedge clk) begin
		mag_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			out_taken = 1;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result transaction, read_value %0d count %0d",
					$realtime, read_value, count);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (read_value !== e.rv) report("read_value", e.rv, read_value);
				if (count !== e.cnt)
					report("count", longint'(e.cnt), longint'(count));
				if (progress !== e.prog)
					report("progress", longint'(e.prog), longint'(progress));
				if (complete !== e.cmp)
					report("complete", longint'(e.cmp), longint'(complete));
				if (restarted !== e.rst)
					report("restarted", longint'(e.rst), longint'(restarted));
				if (saturated !== e.sat)
					report("saturated", longint'(e.sat), longint'(saturated));
			end
		end
	end

	task automatic add_item(op_t o, int q, int s, int p, int x, int y, int z, int t, int m);
		mag_item_t it;
		it.op = o;
		it.qual = q[0];
		it.sns = s[0];
		it.pres = p[0];
		it.x = 16'(x);
		it.y = 16'(y);
		it.z = 16'(z);
		it.tick = t[0];
		it.mom = 5'(m);
		items_to_send.push_back(it);
	endtask

	function automatic int rand_axis();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 511)) - 256;
			1: return int'($urandom_range(0, 16383)) - 8192;
			2: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic add_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 62)
				add_item(OP_SAMPLE, 1, $urandom_range(0, 1), int'($urandom_range(0, 4) != 0),
					rand_axis(), rand_axis(), rand_axis(), $urandom_range(0, 1),
					$urandom_range(0, 31));
			else if (k < 70)
				add_item(OP_SAMPLE, 0, $urandom_range(0, 1), $urandom_range(0, 1),
					rand_axis(), rand_axis(), rand_axis(), $urandom_range(0, 1),
					$urandom_range(0, 31));
			else if (k < 92)
				add_item(OP_READ, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1), rand_axis(), rand_axis(), rand_axis(),
					$urandom_range(0, 1),
					$urandom_range(0, 9) == 0 ? $urandom_range(24, 31) : $urandom_range(0, 23));
			else if (k < 96)
				add_item(OP_SPARE, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1), rand_axis(), rand_axis(), rand_axis(),
					$urandom_range(0, 1), $urandom_range(0, 31));
			else
				add_item(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1), rand_axis(), rand_axis(), rand_axis(),
					$urandom_range(0, 1), $urandom_range(0, 31));
		end
	endtask

	task automatic drain();
		while (items_to_send.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		case (idx)
			REG_SPAN_THR: span_thr = val & 16'hffff;
			REG_MIN_SMP:  min_smp = val & 13'h1fff;
			REG_MAX_SMP:  max_smp = val & 13'h1fff;
			REG_REF_SNS:  ref_sns = val & 1;
			default:      ;
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(int thr, int mn, int mx, int rs);
		write_reg(REG_SPAN_THR, thr);
		write_reg(REG_MIN_SMP, mn);
		write_reg(REG_MAX_SMP, mx);
		write_reg(REG_REF_SNS, rs);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		int settings [6][4] = '{
			'{0, 0, 0, 0}, '{65535, 8191, 8191, 1}, '{50000, 10, 20, 1},
			'{1000, 30, 60, 0}, '{20000, 15, 25, 0}, '{0, 2000, 5000, 0}};
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_SPAN_THR;
		cfg_data = 0;
		in_valid = 0;
		op = OP_SAMPLE;
		qualified = 0;
		sensor = 0;
		present = 0;
		sample_x = 0;
		sample_y = 0;
		sample_z = 0;
		tick_end = 0;
		moment = 0;
		out_stall = 0;
		in_taken = 0;
		out_taken = 0;
		send_gap = 0;
		stall_left = 0;
		rx_hold_cycles = 0;
		quiet_pct = 30;
		errors = 0;
		span_thr = 0;
		min_smp = MIN_RESET;
		max_smp = MAX_RESET;
		ref_sns = 0;
		wipe_sums();
		done_sticky = 0;
		for (int a = 0; a < 3; a++) begin
			ax_max[a] = 0;
			ax_min[a] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: defaults first, then small limits
		add_item(OP_SAMPLE, 1, 0, 1, 32767, 32767, 32767, 1, 0);
		add_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 23);
		add_item(OP_READ, 1, 0, 1, 0, 0, 0, 0, 3);
		drain();
		set_regs(100, 5, 10, 0);
		add_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		add_item(OP_SAMPLE, 0, 0, 1, 1000, 1000, 1000, 1, 0);
		add_item(OP_SAMPLE, 1, 1, 0, -32768, 5, -7, 0, 0);
		for (int i = 0; i < 9; i++)
			add_item(OP_SAMPLE, 1, 0, 1, -32768, -32768, -32768, i % 2, 0);
		add_item(OP_READ, 1, 0, 1, 0, 0, 0, 0, 3);
		add_item(OP_READ, 1, 0, 1, 0, 0, 0, 0, 22);
		add_item(OP_READ, 1, 1, 1, 0, 0, 0, 0, 31);
		add_item(OP_SPARE, 1, 0, 1, 0, 0, 0, 0, 23);
		add_item(OP_SAMPLE, 1, 0, 0, 32767, 32767, 32767, 1, 0);
		add_item(OP_SAMPLE, 1, 0, 1, 1, 2, 3, 1, 0);
		add_item(OP_SAMPLE, 1, 1, 1, 1, 2, 3, 1, 0);
		add_item(OP_READ, 1, 0, 1, 0, 0, 0, 0, 23);
		add_item(OP_CLEAR, 1, 1, 1, 0, 0, 0, 1, 0);
		drain();

		for (int p = 0; p < 6; p++) begin
			set_regs(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
			quiet_pct = (p % 2) ? 85 : 20;
			add_random(120);
			if (p == 3)
				rx_hold_cycles = 1500;
			if (p == 2) begin
				drain();
				quiet_pct = 0;
			end
			add_random(110);
			drain();
		end

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
